@@ src/assert_macros.svh @@
// assertion macros shared by the track byte decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TPBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define TPBD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/tpbd_pkg.sv @@
// types, codes and helpers of the packed track byte decoder
`default_nettype none

package tpbd_pkg;

  // result kinds
  localparam logic [1:0] KIND_ROW   = 2'd0;
  localparam logic [1:0] KIND_INSTR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  // opcode classes, top two bits of an opcode byte
  localparam logic [1:0] OP_NOTE_VOL   = 2'b00;
  localparam logic [1:0] OP_NOTE_SPEED = 2'b01;
  localparam logic [1:0] OP_INSTR      = 2'b10;
  localparam logic [1:0] OP_GAP        = 2'b11;

  // result queue depth and count width
  localparam int QDEPTH = 4;
  localparam int CNT_W  = 3;

  // parse phase
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_OPCODE    = 5'b00010,
    PH_VOL_NOTE  = 5'b00100,
    PH_SPEED     = 5'b01000,
    PH_VOL_SPEED = 5'b10000
  } phase_t;

  // one result item
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] row_or_length;
    logic       note_valid;
    logic [5:0] note;
    logic [5:0] instrument;
    logic       volume_valid;
    logic [3:0] volume_left;
    logic [3:0] volume_right;
    logic       speed_valid;
    logic [4:0] speed;
    logic       stereo;
    logic       last;
  } result_t;

  // up to two results written into the queue in one cycle
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  // result with only kind, length and stereo set
  function automatic result_t mk_item(logic [1:0] kind, logic [6:0] rl, logic st);
    result_t r;
    r               = '0;
    r.kind          = kind;
    r.row_or_length = rl;
    r.stereo        = st;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/tpbd_if.sv @@
// request channels of the track byte decoder
`default_nettype none

// input channel: one track byte per request
interface tpbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       track_start;

  modport source (output valid, output track_byte, output track_start, input ready);
  modport sink (input valid, input track_byte, input track_start, output ready);
endinterface

// result channel: one row or track event per request
interface tpbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] row_or_length;
  logic       note_valid;
  logic [5:0] note;
  logic [5:0] instrument;
  logic       volume_valid;
  logic [3:0] volume_left;
  logic [3:0] volume_right;
  logic       speed_valid;
  logic [4:0] speed;
  logic       stereo;
  logic       last;

  modport source (
    output valid, output kind, output row_or_length, output note_valid, output note,
    output instrument, output volume_valid, output volume_left, output volume_right,
    output speed_valid, output speed, output stereo, output last, input ready
  );
  modport sink (
    input valid, input kind, input row_or_length, input note_valid, input note,
    input instrument, input volume_valid, input volume_left, input volume_right,
    input speed_valid, input speed, input stereo, input last, output ready
  );
endinterface

`default_nettype wire

@@ src/tpbd_decoder.sv @@
// input register, parse state and combinational byte decode
`default_nettype none
`include "assert_macros.svh"

module tpbd_decoder #(
  parameter int TRACK_ROWS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_start,
  input  wire logic            room,
  output tpbd_pkg::push_t      push
);
  import tpbd_pkg::*;

  localparam int RowW = $clog2(TRACK_ROWS + 1);
  localparam int SumW = ((RowW > 7) ? RowW : 7) + 1;
  localparam logic [SumW-1:0] TrLast = SumW'(TRACK_ROWS - 1);
  localparam logic [RowW-1:0] TrRows = RowW'(TRACK_ROWS);
  localparam logic [6:0]      TrLen  = 7'(TRACK_ROWS % 128);

  // input register
  logic       vld_r;
  logic [7:0] byte_r;
  logic       start_r;
  logic       fire;

  // parse state
  logic [RowW-1:0] row_r, row_nxt;
  logic [5:0]      inst_r, inst_nxt;
  phase_t          phase_r, phase_nxt;
  logic [6:0]      pn_r, pn_nxt;
  logic [4:0]      ps_r, ps_nxt;
  logic            ear_r, ear_nxt;
  logic            st_r, st_nxt;

  assign fire     = vld_r && room;
  assign in_ready = !vld_r || room;

  // input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r  <= in_byte;
      start_r <= in_start;
    end
  end

  // decode one byte
  always_comb begin
    logic [5:0]      low;
    logic [SumW-1:0] space;
    logic [SumW-1:0] gap_sum;
    logic [RowW-1:0] row_inc;
    logic            do_fin;
    logic            fin_vol;
    logic [3:0]      hi;
    logic [3:0]      lo;

    low     = byte_r[5:0];
    hi      = byte_r[7:4];
    lo      = byte_r[3:0];
    space   = SumW'(low) + SumW'(1);
    gap_sum = '0;
    row_inc = '0;
    do_fin  = 1'b0;
    fin_vol = 1'b0;

    row_nxt   = row_r;
    inst_nxt  = inst_r;
    phase_nxt = phase_r;
    pn_nxt    = pn_r;
    ps_nxt    = ps_r;
    ear_nxt   = ear_r;
    st_nxt    = st_r;
    push      = '0;

    if (fire) begin
      // a track start clears the state and makes this byte an opcode
      if (start_r) begin
        row_nxt   = '0;
        inst_nxt  = '0;
        phase_nxt = PH_OPCODE;
        pn_nxt    = '0;
        ps_nxt    = '0;
        ear_nxt   = 1'b0;
        st_nxt    = 1'b0;
      end
      gap_sum = SumW'(row_nxt) + space;

      case (phase_nxt)
        PH_OPCODE: begin
          case (byte_r[7:6])
            OP_INSTR: begin
              inst_nxt           = low;
              push.v0            = 1'b1;
              push.r0            = mk_item(KIND_INSTR, 7'd0, st_nxt);
              push.r0.instrument = low;
              push.r0.last       = 1'b1;
            end
            OP_NOTE_VOL, OP_NOTE_SPEED: begin
              pn_nxt    = (low != 6'd0) ? {1'b1, low - 6'd1} : 7'd0;
              ps_nxt    = '0;
              ear_nxt   = 1'b0;
              phase_nxt = (byte_r[7:6] == OP_NOTE_VOL) ? PH_VOL_NOTE : PH_SPEED;
            end
            OP_GAP: begin
              if (space > TrLast || gap_sum > TrLast) begin
                // gap runs past the last row
                phase_nxt = PH_IDLE;
                push.v0   = 1'b1;
                if (row_nxt != '0) begin
                  push.r0 = mk_item(KIND_END, TrLen, st_nxt);
                end else begin
                  push.r0 = mk_item(KIND_EMPTY, 7'd0, st_nxt);
                end
                push.r0.last = 1'b1;
              end else begin
                row_nxt = gap_sum[RowW-1:0];
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        PH_VOL_NOTE, PH_VOL_SPEED: begin
          do_fin  = 1'b1;
          fin_vol = 1'b1;
        end
        PH_SPEED: begin
          if (lo == 4'd0) begin
            ear_nxt = 1'b1;
          end else begin
            ps_nxt = {1'b0, lo} + 5'd1;
          end
          if (byte_r[7]) begin
            phase_nxt = PH_VOL_SPEED;
          end else begin
            do_fin = 1'b1;
          end
        end
        default: begin
          // idle or ended track: byte ignored
        end
      endcase

      // emit the completed row and a track end if one is due
      if (do_fin) begin
        st_nxt  = st_nxt | (fin_vol && (hi != lo));
        push.v0 = 1'b1;
        push.r0 = mk_item(KIND_ROW, 7'(SumW'(row_nxt)), st_nxt);
        if (fin_vol && byte_r != 8'hff) begin
          push.r0.volume_valid = 1'b1;
          push.r0.volume_left  = ~hi;
          push.r0.volume_right = ~lo;
        end
        if (pn_nxt[6]) begin
          push.r0.note_valid = 1'b1;
          push.r0.note       = pn_nxt[5:0];
          push.r0.instrument = inst_nxt;
        end
        if (ps_nxt != 5'd0) begin
          push.r0.speed_valid = 1'b1;
          push.r0.speed       = ps_nxt;
        end
        if (ear_nxt) begin
          // zero speed: length is this row plus one
          push.v1   = 1'b1;
          push.r1   = mk_item(KIND_END, 7'(SumW'(row_nxt) + SumW'(1)), st_nxt);
          phase_nxt = PH_IDLE;
        end else begin
          row_inc = row_nxt + RowW'(1);
          row_nxt = row_inc;
          if (row_inc >= TrRows) begin
            push.v1   = 1'b1;
            push.r1   = mk_item(KIND_END, TrLen, st_nxt);
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_OPCODE;
          end
        end
        push.r0.last = !push.v1;
        push.r1.last = push.v1;
        pn_nxt       = '0;
        ps_nxt       = '0;
        ear_nxt      = 1'b0;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      inst_r  <= '0;
      phase_r <= PH_IDLE;
      pn_r    <= '0;
      ps_r    <= '0;
      ear_r   <= 1'b0;
      st_r    <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      inst_r  <= inst_nxt;
      phase_r <= phase_nxt;
      pn_r    <= pn_nxt;
      ps_r    <= ps_nxt;
      ear_r   <= ear_nxt;
      st_r    <= st_nxt;
    end
  end

  // checks
  `TPBD_ASSERT(a_second_needs_first, push.v1 |-> push.v0, "second result without first")
  `TPBD_ASSERT(a_last_marks, push.v0 |-> (push.r0.last != push.v1), "last flag misplaced")
  `TPBD_ASSERT(a_second_is_end, push.v1 |-> (push.r1.kind == KIND_END && push.r1.last),
               "second result is not a track end")
  `TPBD_NEVER(a_push_idle, (push.v0 && !fire), "result pushed without a decoded byte")

endmodule

`default_nettype wire

@@ src/tpbd_result_queue.sv @@
// shifting result queue that takes up to two results per cycle
`default_nettype none
`include "assert_macros.svh"

module tpbd_result_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tpbd_pkg::push_t  push,
  output logic                  room,
  output tpbd_pkg::result_t     head,
  output logic                  head_vld,
  input  wire logic             head_rdy
);
  import tpbd_pkg::*;

  result_t            q_r   [QDEPTH];
  result_t            q_nxt [QDEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   base;
  logic               pop;

  assign head_vld = (count_r != '0);
  assign head     = q_r[0];
  assign pop      = head_vld && head_rdy;
  // room for two results regardless of this cycle's pop
  assign room     = (count_r <= CNT_W'(QDEPTH - 2));

  // shift on pop, write new results behind the survivors
  always_comb begin
    base = count_r - CNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_nxt[i] = q_r[(i < QDEPTH - 1) ? i + 1 : i];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push.v0 && base == CNT_W'(i)) begin
        q_nxt[i] = push.r0;
      end
      if (push.v1 && (base + CNT_W'(1)) == CNT_W'(i)) begin
        q_nxt[i] = push.r1;
      end
    end
    count_nxt = base + CNT_W'(push.v0) + CNT_W'(push.v1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // checks
  `TPBD_ASSERT(a_count_bound, count_r <= CNT_W'(QDEPTH), "queue count beyond depth")
  `TPBD_NEVER(a_push_no_room, (push.v0 && !room), "push into a full queue")
  `TPBD_ASSERT(a_pop_only, (pop && !push.v0) |=> (count_r == $past(count_r) - CNT_W'(1)),
               "queue count lost track on pop")

endmodule

`default_nettype wire

@@ src/tracker_pattern_byte_decoder_top.sv @@
// An accepted byte is held in the input register, decoded when the result
// queue has room; its results are registered in the queue, then offered.
// Throughput: one byte per cycle while the queue has room; a byte that ends a
// row with a track end gives two results, one at a time on the result port.
// The 4-entry result queue accepts decoding while it has room for two results.
// Reset: synchronous active-low rst_n; the decoder starts idle (track ended)
// and ignores bytes until one arrives with track_start set.
`default_nettype none

module tracker_pattern_byte_decoder_top #(
  parameter int TRACK_ROWS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tpbd_in_if.sink         in_chan,
  tpbd_out_if.source      out_chan
);
  import tpbd_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  // byte decoder with parse state
  tpbd_decoder #(
    .TRACK_ROWS (TRACK_ROWS)
  ) u_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_byte  (in_chan.track_byte),
    .in_start (in_chan.track_start),
    .room     (room),
    .push     (push)
  );

  // result queue
  tpbd_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .head     (head),
    .head_vld (out_chan.valid),
    .head_rdy (out_chan.ready)
  );

  // result fields
  assign out_chan.kind          = head.kind;
  assign out_chan.row_or_length = head.row_or_length;
  assign out_chan.note_valid    = head.note_valid;
  assign out_chan.note          = head.note;
  assign out_chan.instrument    = head.instrument;
  assign out_chan.volume_valid  = head.volume_valid;
  assign out_chan.volume_left   = head.volume_left;
  assign out_chan.volume_right  = head.volume_right;
  assign out_chan.speed_valid   = head.speed_valid;
  assign out_chan.speed         = head.speed;
  assign out_chan.stereo        = head.stereo;
  assign out_chan.last          = head.last;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench of the packed track byte decoder: directed and random track streams
`timescale 1ns / 100ps

module testbench;
  import tpbd_pkg::*;

  localparam int ROWS        = 64;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n;

  tpbd_in_if  in_chan ();
  tpbd_out_if out_chan ();

  tracker_pattern_byte_decoder_top #(
    .TRACK_ROWS(ROWS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // decoder state as seen by the checker
  int unsigned row_cnt;
  logic [5:0]  cur_instr;
  phase_t      track_phase;
  logic        note_ok;
  logic [5:0]  pend_note;
  logic [4:0]  pend_speed;
  logic        end_after;
  logic        stereo_seen;

  result_t expected_events[$];
  int      mismatches = 0;
  int      cycle_cnt  = 0;
  bit      in_gaps    = 1'b0;
  bit      out_stalls = 1'b0;

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_chan.ready <= out_stalls ? ($urandom_range(99) >= 26) : 1'b1;
  end

  // clear the decoder state, as on reset or track start
  function automatic void clear_tracker();
    row_cnt     = 0;
    cur_instr   = '0;
    track_phase = PH_IDLE;
    note_ok     = 1'b0;
    pend_note   = '0;
    pend_speed  = '0;
    end_after   = 1'b0;
    stereo_seen = 1'b0;
  endfunction

  // emit the pending row and a track end if one is due
  function automatic void close_row(input bit has_vol, input logic [7:0] vb);
    result_t    r;
    result_t    e;
    bit         has_end;
    logic [3:0] vl;
    logic [3:0] vr;
    r = '0;
    e = '0;
    has_end = 1'b0;
    r.kind = KIND_ROW;
    r.row_or_length = 7'(row_cnt);
    if (has_vol) begin
      vl = 4'd15 - vb[7:4];
      vr = 4'd15 - vb[3:0];
      if (vl != vr) stereo_seen = 1'b1;
      if (vl != 4'd0 || vr != 4'd0) begin
        r.volume_valid = 1'b1;
        r.volume_left  = vl;
        r.volume_right = vr;
      end
    end
    r.stereo = stereo_seen;
    if (note_ok) begin
      r.note_valid = 1'b1;
      r.note       = pend_note;
      r.instrument = cur_instr;
    end
    if (pend_speed != 5'd0) begin
      r.speed_valid = 1'b1;
      r.speed       = pend_speed;
    end
    // zero speed ends the track after this row
    if (end_after) begin
      has_end = 1'b1;
      e.row_or_length = 7'(row_cnt + 1);
      track_phase = PH_IDLE;
    end else begin
      row_cnt++;
      if (row_cnt >= ROWS) begin
        has_end = 1'b1;
        e.row_or_length = 7'(ROWS);
        track_phase = PH_IDLE;
      end else begin
        track_phase = PH_OPCODE;
      end
    end
    note_ok    = 1'b0;
    pend_note  = '0;
    pend_speed = '0;
    end_after  = 1'b0;
    r.last = !has_end;
    expected_events.push_back(r);
    if (has_end) begin
      e.kind   = KIND_END;
      e.stereo = stereo_seen;
      e.last   = 1'b1;
      expected_events.push_back(e);
    end
  endfunction

  // advance the decoder by one accepted byte
  function automatic void decode_byte(input logic [7:0] b, input logic st);
    result_t     r;
    int unsigned gap;
    r = '0;
    if (st) begin
      clear_tracker();
      track_phase = PH_OPCODE;
    end
    case (track_phase)
      PH_OPCODE: begin
        case (b[7:6])
          OP_INSTR: begin
            cur_instr    = b[5:0];
            r.kind       = KIND_INSTR;
            r.instrument = b[5:0];
            r.stereo     = stereo_seen;
            r.last       = 1'b1;
            expected_events.push_back(r);
          end
          OP_NOTE_VOL, OP_NOTE_SPEED: begin
            note_ok     = (b[5:0] != 6'd0);
            pend_note   = note_ok ? b[5:0] - 6'd1 : 6'd0;
            pend_speed  = '0;
            end_after   = 1'b0;
            track_phase = (b[7:6] == OP_NOTE_VOL) ? PH_VOL_NOTE : PH_SPEED;
          end
          default: begin
            gap = b[5:0] + 1;
            if (gap > ROWS - 1 || row_cnt + gap > ROWS - 1) begin
              // gap runs past the last row
              track_phase = PH_IDLE;
              if (row_cnt > 0) begin
                r.kind = KIND_END;
                r.row_or_length = 7'(ROWS);
              end else begin
                r.kind = KIND_EMPTY;
              end
              r.stereo = stereo_seen;
              r.last   = 1'b1;
              expected_events.push_back(r);
            end else begin
              row_cnt += gap;
            end
          end
        endcase
      end
      PH_VOL_NOTE, PH_VOL_SPEED: close_row(1'b1, b);
      PH_SPEED: begin
        if (b[3:0] == 4'd0) end_after = 1'b1;
        else pend_speed = 5'(b[3:0]) + 5'd1;
        if (b[7]) track_phase = PH_VOL_SPEED;
        else close_row(1'b0, 8'd0);
      end
      default: ;
    endcase
  endfunction

  // compare one field of a result
  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_events.size() == 0) begin
        $error("result with nothing expected: kind %0d", out_chan.kind);
        mismatches++;
      end else begin
        e = expected_events.pop_front();
        check_field("kind", e.kind, out_chan.kind);
        check_field("row_or_length", e.row_or_length, out_chan.row_or_length);
        check_field("note_valid", e.note_valid, out_chan.note_valid);
        check_field("note", e.note, out_chan.note);
        check_field("instrument", e.instrument, out_chan.instrument);
        check_field("volume_valid", e.volume_valid, out_chan.volume_valid);
        check_field("volume_left", e.volume_left, out_chan.volume_left);
        check_field("volume_right", e.volume_right, out_chan.volume_right);
        check_field("speed_valid", e.speed_valid, out_chan.speed_valid);
        check_field("speed", e.speed, out_chan.speed);
        check_field("stereo", e.stereo, out_chan.stereo);
        check_field("last", e.last, out_chan.last);
      end
    end
  end

  // send one byte request; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic st);
    while (in_gaps && $urandom_range(99) < 26) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.track_byte  <= b;
    in_chan.track_start <= st;
    do @(posedge clk); while (!in_chan.ready);
    decode_byte(b, st);
    @(negedge clk);
  endtask

  // hold the sender until every expected result has come
  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  // bytes before any track start are ignored
  task automatic test_stray_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    wait_drain();
  endtask

  // every opcode class with field extremes
  task automatic test_opcodes();
    send_byte(8'hff, 1'b1);   // empty track end
    send_byte(8'h80, 1'b1);   // instrument 0
    send_byte(8'hbf, 1'b0);   // instrument 63
    send_byte(8'h00, 1'b0);   // no note, both volumes zero
    send_byte(8'hff, 1'b0);
    send_byte(8'h3f, 1'b0);   // note 62, full volume on one side
    send_byte(8'h0f, 1'b0);
    send_byte(8'h41, 1'b0);   // speed 16 with volume byte
    send_byte(8'h8f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);   // speed 2, no volume
    send_byte(8'h01, 1'b0);
    send_byte(8'hc2, 1'b0);   // gap inside the track
    wait_drain();
  endtask

  // zero speed, bytes after end, restart mid-row, row limit, gap past end
  task automatic test_track_ends();
    send_byte(8'h45, 1'b0);
    send_byte(8'h70, 1'b0);   // zero speed ends after this row
    send_byte(8'h81, 1'b0);   // ignored after the end
    send_byte(8'h00, 1'b1);
    send_byte(8'h3f, 1'b1);   // restart drops the partial row
    send_byte(8'h55, 1'b0);
    send_byte(8'hfe, 1'b0);   // gap past the end after a row
    send_byte(8'hfe, 1'b1);   // jump to the last row
    send_byte(8'h01, 1'b0);
    send_byte(8'hff, 1'b0);   // last row reaches the row count
    wait_drain();
  endtask

  // random opcode, weighted toward notes, mostly short gaps
  function automatic logic [7:0] random_opcode();
    int p;
    p = $urandom_range(99);
    if (p < 15) return {OP_INSTR, 6'($urandom)};
    if (p < 50) return {OP_NOTE_VOL, 6'($urandom)};
    if (p < 85) return {OP_NOTE_SPEED, 6'($urandom)};
    if (p < 95) return {OP_GAP, 6'($urandom_range(0, 7))};
    return {OP_GAP, 6'($urandom)};
  endfunction

  // well-formed tracks with random content and some noise
  task automatic test_random_tracks(input int n_items, input bit gaps);
    int         sent;
    int         p;
    logic [7:0] b;
    logic       st;
    in_gaps    = gaps;
    out_stalls = gaps;
    sent = 0;
    while (sent < n_items) begin
      p  = $urandom_range(99);
      st = 1'b0;
      if (p < 3) begin
        b  = 8'($urandom);
        st = 1'($urandom);
      end else if (track_phase == PH_IDLE) begin
        st = (p < 90);
        b  = st ? random_opcode() : 8'($urandom);
      end else if (p < 5) begin
        st = 1'b1;
        b  = random_opcode();
      end else if (track_phase == PH_OPCODE) begin
        b = random_opcode();
      end else if (track_phase == PH_SPEED) begin
        b = {1'($urandom), 3'($urandom),
             ($urandom_range(99) < 10) ? 4'd0 : 4'($urandom)};
      end else begin
        b = 8'($urandom);
      end
      if (st || track_phase != PH_IDLE) sent++;
      send_byte(b, st);
    end
    wait_drain();
  endtask

  // main sequence
  initial begin
    in_chan.valid       = 1'b0;
    in_chan.track_byte  = '0;
    in_chan.track_start = 1'b0;
    out_chan.ready      = 1'b0;
    rst_n               = 1'b0;
    clear_tracker();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_stray_bytes();
    test_opcodes();
    test_track_ends();
    test_random_tracks(150, 1'b0);
    test_random_tracks(250, 1'b1);
    test_random_tracks(250, 1'b1);

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
